FILE: rtl/rip_pkg.sv
package rip_pkg;

  // field and datapath widths
  localparam int unsigned DataW      = 16;
  localparam int unsigned DiffW      = DataW + 1;
  localparam int unsigned ProdW      = 32;
  localparam int unsigned SatW       = ProdW + 2;
  localparam int unsigned DistW      = DataW + 2;
  localparam int unsigned PlayerIdxW = 2;
  localparam int unsigned CfgIdxW    = 3;

  // hardware slots for rods and players
  localparam int unsigned NumRodsHw    = 2;
  localparam int unsigned NumPlayersHw = 3;

  // parameter defaults
  localparam int unsigned RodCountDef      = 2;
  localparam int unsigned PlayersPerRodDef = 3;

  // queue depths
  localparam int unsigned MidDepth = 2;
  localparam int unsigned ResDepth = 2;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ROD_LINE_0    = 3'd0,
    REG_ROD_LINE_1    = 3'd1,
    REG_CENTER_MIN    = 3'd2,
    REG_CENTER_MAX    = 3'd3,
    REG_OFFSET_FIRST  = 3'd4,
    REG_OFFSET_SECOND = 3'd5,
    REG_OFFSET_THIRD  = 3'd6,
    REG_PLAYERS       = 3'd7
  } cfg_reg_e;

  // register reset values
  localparam logic [DataW-1:0]      RstRodLine0   = 16'd2560;
  localparam logic [DataW-1:0]      RstRodLine1   = 16'd7680;
  localparam logic [DataW-1:0]      RstCenterMin  = 16'd2816;
  localparam logic [DataW-1:0]      RstCenterMax  = 16'd5376;
  localparam logic [DataW-1:0]      RstOffset0    = 16'hF800;
  localparam logic [DataW-1:0]      RstOffset1    = 16'h0000;
  localparam logic [DataW-1:0]      RstOffset2    = 16'h0800;
  localparam logic [PlayerIdxW-1:0] RstPlayers    = 2'd3;

  localparam logic signed [SatW-1:0] SatMax = 34'sd32767;
  localparam logic signed [SatW-1:0] SatMin = -34'sd32768;

  typedef struct packed {
    logic [NumRodsHw-1:0][DataW-1:0]    rod_line;
    logic [DataW-1:0]                   center_min;
    logic [DataW-1:0]                   center_max;
    logic [NumPlayersHw-1:0][DataW-1:0] offset;
    logic [PlayerIdxW-1:0]              players;
  } cfg_t;

  // classified item between front and back
  typedef struct packed {
    logic [DataW-1:0]                bx;
    logic [DataW-1:0]                vy;
    logic [NumRodsHw-1:0][DataW-1:0] meas;
    logic [NumRodsHw-1:0][ProdW-1:0] prod;
    logic [NumRodsHw-1:0]            go;
  } mid_t;

  // item fields that ride alongside the divider
  typedef struct packed {
    logic [DataW-1:0]                bx;
    logic [NumRodsHw-1:0][DataW-1:0] meas;
    logic [NumRodsHw-1:0]            go;
  } side_t;

  typedef struct packed {
    logic [NumRodsHw-1:0][DataW-1:0]      target;
    logic [NumRodsHw-1:0]                 moved;
    logic [NumRodsHw-1:0][PlayerIdxW-1:0] chosen;
  } res_t;

  function automatic logic [DataW-1:0] sat_data(input logic signed [SatW-1:0] v);
    logic [DataW-1:0] r;
    if (v > SatMax) begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end else if (v < SatMin) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/rip_fifo.sv
module rip_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Depth-1:0][Width-1:0] mem_q;
  logic [PtrW-1:0]             wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) == (wr_q == rd_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

FILE: rtl/rip_front.sv
module rip_front #(
  parameter int unsigned RodCount = rip_pkg::RodCountDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rip_pkg::cfg_t                   cfg_i,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [rip_pkg::DataW-1:0]       ball_x_i,
  input  logic [rip_pkg::DataW-1:0]       ball_y_i,
  input  logic [rip_pkg::DataW-1:0]       ball_vx_i,
  input  logic [rip_pkg::DataW-1:0]       ball_vy_i,
  input  logic [rip_pkg::NumRodsHw-1:0][rip_pkg::DataW-1:0] meas_i,
  output logic                            mid_push_o,
  output rip_pkg::mid_t                   mid_o,
  input  logic                            mid_full_i
);

  localparam int unsigned DataW = rip_pkg::DataW;
  localparam int unsigned DiffW = rip_pkg::DiffW;
  localparam int unsigned NRods = rip_pkg::NumRodsHw;

  logic                            f_valid_q, f_valid_d;
  logic                            accept;
  logic                            vy_pos, vy_nz;
  logic [DataW-1:0]                bx_q, vx_q, vy_q;
  logic [NRods-1:0][DataW-1:0]     meas_q;
  logic [NRods-1:0][DiffW-1:0]     diff_d, diff_q;
  logic [NRods-1:0]                go_d, go_q;

  assign full_o    = f_valid_q & mid_full_i;
  assign accept    = push_i & ~full_o;
  assign f_valid_d = accept | (f_valid_q & mid_full_i);

  assign vy_nz  = (ball_vy_i != '0);
  assign vy_pos = vy_nz & ~ball_vy_i[DataW-1];

  for (genvar r = 0; r < NRods; r++) begin : g_rod
    logic signed [DataW-1:0]     line_s, by_s;
    logic                        ahead;
    logic signed [DiffW+DataW-1:0] prod_full;

    assign line_s = $signed(cfg_i.rod_line[r]);
    assign by_s   = $signed(ball_y_i);
    // equal y counts as not ahead
    assign ahead  = vy_pos ? (line_s > by_s) : (line_s < by_s);
    assign go_d[r] = vy_nz & ahead & (r < RodCount);
    assign diff_d[r] = {ball_y_i[DataW-1], ball_y_i}
                     - {cfg_i.rod_line[r][DataW-1], cfg_i.rod_line[r]};

    // magnitude stays below 2^31, so 32 bits hold the product exactly
    assign prod_full    = $signed(diff_q[r]) * $signed(vx_q);
    assign mid_o.prod[r] = prod_full[rip_pkg::ProdW-1:0];
    assign mid_o.meas[r] = meas_q[r];
    assign mid_o.go[r]   = go_q[r];
  end

  assign mid_o.bx   = bx_q;
  assign mid_o.vy   = vy_q;
  assign mid_push_o = f_valid_q & ~mid_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bx_q   <= ball_x_i;
      vx_q   <= ball_vx_i;
      vy_q   <= ball_vy_i;
      meas_q <= meas_i;
      diff_q <= diff_d;
      go_q   <= go_d;
    end
  end

endmodule

FILE: rtl/rip_div.sv
module rip_div #(
  parameter int unsigned DvdW = rip_pkg::ProdW,
  parameter int unsigned DvsW = rip_pkg::DataW
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DvdW-1:0] dvd_i,
  input  logic [DvsW-1:0] dvs_i,
  output logic [DvdW-1:0] quo_o,
  output logic            neg_o
);

  // stage 0 takes magnitudes, stages 1..DvdW each retire one quotient bit
  logic [DvdW:0][DvdW-1:0] wrk_q;
  logic [DvdW:0][DvsW-1:0] rem_q;
  logic [DvdW:0][DvsW-1:0] dvs_q;
  logic [DvdW:0]           neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wrk_q[0] <= dvd_i[DvdW-1] ? (~dvd_i + 1'b1) : dvd_i;
      dvs_q[0] <= dvs_i[DvsW-1] ? (~dvs_i + 1'b1) : dvs_i;
      rem_q[0] <= '0;
      neg_q[0] <= dvd_i[DvdW-1] ^ dvs_i[DvsW-1];
    end
  end

  for (genvar k = 0; k < DvdW; k++) begin : g_step
    logic [DvsW:0] trial;
    logic [DvsW:0] diff;
    logic          fits;

    assign trial = {rem_q[k], wrk_q[k][DvdW-1]};
    assign diff  = trial - {1'b0, dvs_q[k]};
    assign fits  = (trial >= {1'b0, dvs_q[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= fits ? diff[DvsW-1:0] : trial[DvsW-1:0];
        wrk_q[k+1] <= {wrk_q[k][DvdW-2:0], fits};
        dvs_q[k+1] <= dvs_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  assign quo_o = wrk_q[DvdW];
  assign neg_o = neg_q[DvdW];

endmodule

FILE: rtl/rip_back.sv
module rip_back #(
  parameter int unsigned RodCount      = rip_pkg::RodCountDef,
  parameter int unsigned PlayersPerRod = rip_pkg::PlayersPerRodDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rip_pkg::cfg_t cfg_i,
  input  logic          mid_empty_i,
  input  rip_pkg::mid_t mid_i,
  output logic          mid_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output rip_pkg::res_t res_o
);

  localparam int unsigned DataW  = rip_pkg::DataW;
  localparam int unsigned ProdW  = rip_pkg::ProdW;
  localparam int unsigned SatW   = rip_pkg::SatW;
  localparam int unsigned DistW  = rip_pkg::DistW;
  localparam int unsigned IdxW   = rip_pkg::PlayerIdxW;
  localparam int unsigned NRods  = rip_pkg::NumRodsHw;
  localparam int unsigned NPl    = rip_pkg::NumPlayersHw;
  localparam int unsigned DivLat = ProdW + 1;
  localparam logic [IdxW-1:0] PprMax = IdxW'(PlayersPerRod);

  logic                         adv;
  logic [DivLat-1:0]            v_q;
  rip_pkg::side_t [DivLat-1:0]  side_q;
  rip_pkg::side_t               side_in;
  logic                         e_valid_q;
  rip_pkg::side_t               e_side_q;
  logic [NRods-1:0][DataW-1:0]  est_d, est_q;
  logic [NRods-1:0][DataW-1:0]  store_q, store_d;
  logic [IdxW-1:0]              np_eff;

  logic [NRods-1:0][NPl-1:0]             hit;
  logic [NRods-1:0][NPl-1:0][DistW-1:0]  dist_abs;
  logic [NRods-1:0][NPl-1:0][DataW-1:0]  tgt;
  logic [NRods-1:0]                      found;
  logic [NRods-1:0][IdxW-1:0]            best;
  logic [NRods-1:0]                      moved;

  // whole back pipeline moves together; only a waiting result holds it
  assign adv        = ~(e_valid_q & res_full_i);
  assign mid_pop_o  = adv & ~mid_empty_i;
  assign res_push_o = e_valid_q & ~res_full_i;

  assign np_eff = (cfg_i.players > PprMax) ? PprMax : cfg_i.players;

  assign side_in.bx   = mid_i.bx;
  assign side_in.meas = mid_i.meas;
  assign side_in.go   = mid_i.go;

  for (genvar r = 0; r < NRods; r++) begin : g_rod
    if (r < RodCount) begin : g_div
      logic [ProdW-1:0]        quo;
      logic                    neg;
      logic signed [SatW-1:0]  bx_w, quo_w;

      rip_div #(
        .DvdW (ProdW),
        .DvsW (DataW)
      ) u_div (
        .clk_i (clk_i),
        .en_i  (adv),
        .dvd_i (mid_i.prod[r]),
        .dvs_i (mid_i.vy),
        .quo_o (quo),
        .neg_o (neg)
      );

      assign bx_w  = $signed({{(SatW-DataW){side_q[DivLat-1].bx[DataW-1]}},
                              side_q[DivLat-1].bx});
      assign quo_w = $signed({{(SatW-ProdW){1'b0}}, quo});
      // quotient truncates toward zero, sign applied after
      assign est_d[r] = rip_pkg::sat_data(neg ? (bx_w + quo_w) : (bx_w - quo_w));
    end else begin : g_nodiv
      assign est_d[r] = '0;
    end

    for (genvar j = 0; j < NPl; j++) begin : g_pl
      logic signed [DataW:0]   off_n, est_n, lo, hi;
      logic signed [DistW-1:0] delta;
      logic signed [SatW-1:0]  tgt_w;

      assign off_n = $signed({cfg_i.offset[j][DataW-1], cfg_i.offset[j]});
      assign est_n = $signed({est_q[r][DataW-1], est_q[r]});
      assign lo    = $signed({cfg_i.center_min[DataW-1], cfg_i.center_min}) + off_n;
      assign hi    = $signed({cfg_i.center_max[DataW-1], cfg_i.center_max}) + off_n;
      assign hit[r][j] = (IdxW'(j) < np_eff) && (lo <= est_n) && (est_n <= hi);

      assign delta = $signed({{(DistW-DataW){est_q[r][DataW-1]}}, est_q[r]})
                   - $signed({{(DistW-DataW){e_side_q.meas[r][DataW-1]}},
                              e_side_q.meas[r]})
                   - $signed({{(DistW-DataW){cfg_i.offset[j][DataW-1]}},
                              cfg_i.offset[j]});
      assign dist_abs[r][j] = delta[DistW-1] ? (~delta + 1'b1) : delta;

      assign tgt_w = $signed({{(SatW-DataW-1){est_n[DataW]}}, est_n})
                   - $signed({{(SatW-DataW-1){off_n[DataW]}}, off_n});
      assign tgt[r][j] = rip_pkg::sat_data(tgt_w);
    end

    logic [DistW-1:0] best_dist;

    // nearest player wins, lower index on a strict tie
    always_comb begin
      found[r]  = 1'b0;
      best[r]   = '0;
      best_dist = '0;
      for (int j = 0; j < NPl; j++) begin
        if (hit[r][j] && (!found[r] || dist_abs[r][j] < best_dist)) begin
          found[r]  = 1'b1;
          best[r]   = IdxW'(j);
          best_dist = dist_abs[r][j];
        end
      end
    end

    assign moved[r] = e_valid_q & e_side_q.go[r] & found[r];
  end

  always_comb begin
    store_d = store_q;
    for (int r = 0; r < NRods; r++) begin
      res_o.moved[r]  = moved[r];
      res_o.chosen[r] = moved[r] ? best[r] : '0;
      if (moved[r]) begin
        store_d[r] = tgt[r][best[r]];
      end
      res_o.target[r] = store_d[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q       <= '0;
      e_valid_q <= 1'b0;
      store_q   <= '0;
    end else begin
      if (adv) begin
        v_q[0] <= mid_pop_o;
        for (int k = 1; k < DivLat; k++) begin
          v_q[k] <= v_q[k-1];
        end
        e_valid_q <= v_q[DivLat-1];
      end
      if (res_push_o) begin
        store_q <= store_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int k = 1; k < DivLat; k++) begin
        side_q[k] <= side_q[k-1];
      end
      e_side_q <= side_q[DivLat-1];
      est_q    <= est_d;
    end
  end

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_valid_q && res_full_i) |=> e_valid_q)
    else $error("stalled result lost");

  a_store_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (store_q[0] == $past(res_o.target[0])))
    else $error("held target differs from delivered target");

  a_chosen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.moved[0]) |-> (res_o.chosen[0] < np_eff))
    else $error("chosen player outside active set");
`endif

endmodule

FILE: rtl/rod_intercept_planner.sv
// rod intercept planner
//
// input channel: push/full; a ball state transaction (position, velocity and
// both measured rod centers) is taken at a clock edge with push high and full
// low. result channel: empty/pop; while empty is low the oldest result sits
// on the target, moved and chosen ports, and it leaves at an edge with pop
// high. config port: cfg_we_i writes register cfg_idx_i at once; write only
// while no transaction is in flight.
//
// throughput: one transaction per cycle while the result side keeps popping.
// path from acceptance to the result ports: front register, classified
// queue, 33-stage pipelined divider, estimate register, result queue; the
// divider has one stage per product bit plus one.
//
// reset clears both queues, the pipeline valids, the held targets (zero) and
// loads the register defaults. when the receiver stops popping, the result
// queue fills, the back pipeline freezes in place, the middle queue fills and
// full rises; nothing is dropped and accepting resumes as pop returns.
module rod_intercept_planner #(
  parameter int unsigned RodCount      = rip_pkg::RodCountDef,
  parameter int unsigned PlayersPerRod = rip_pkg::PlayersPerRodDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write
  input  logic                                 cfg_we_i,
  input  logic [rip_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [rip_pkg::DataW-1:0]            cfg_wdata_i,
  // input queue side
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [rip_pkg::DataW-1:0]     ball_x_i,
  input  logic signed [rip_pkg::DataW-1:0]     ball_y_i,
  input  logic signed [rip_pkg::DataW-1:0]     ball_vx_i,
  input  logic signed [rip_pkg::DataW-1:0]     ball_vy_i,
  input  logic signed [rip_pkg::DataW-1:0]     measured_x_0_i,
  input  logic signed [rip_pkg::DataW-1:0]     measured_x_1_i,
  // result queue side
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [rip_pkg::DataW-1:0]     target_x_0_o,
  output logic signed [rip_pkg::DataW-1:0]     target_x_1_o,
  output logic                                 moved_0_o,
  output logic                                 moved_1_o,
  output logic [rip_pkg::PlayerIdxW-1:0]       chosen_0_o,
  output logic [rip_pkg::PlayerIdxW-1:0]       chosen_1_o
);

  localparam int unsigned MidW = $bits(rip_pkg::mid_t);
  localparam int unsigned ResW = $bits(rip_pkg::res_t);

  rip_pkg::cfg_t cfg_q;

  logic                 mid_push, mid_full, mid_pop, mid_empty;
  rip_pkg::mid_t        mid_wr, mid_rd;
  logic                 res_push, res_full;
  rip_pkg::res_t        res_wr, res_rd;
  logic [rip_pkg::NumRodsHw-1:0][rip_pkg::DataW-1:0] meas;

  // configuration registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rod_line[0] <= rip_pkg::RstRodLine0;
      cfg_q.rod_line[1] <= rip_pkg::RstRodLine1;
      cfg_q.center_min  <= rip_pkg::RstCenterMin;
      cfg_q.center_max  <= rip_pkg::RstCenterMax;
      cfg_q.offset[0]   <= rip_pkg::RstOffset0;
      cfg_q.offset[1]   <= rip_pkg::RstOffset1;
      cfg_q.offset[2]   <= rip_pkg::RstOffset2;
      cfg_q.players     <= rip_pkg::RstPlayers;
    end else if (cfg_we_i) begin
      case (rip_pkg::cfg_reg_e'(cfg_idx_i))
        rip_pkg::REG_ROD_LINE_0:    cfg_q.rod_line[0] <= cfg_wdata_i;
        rip_pkg::REG_ROD_LINE_1:    cfg_q.rod_line[1] <= cfg_wdata_i;
        rip_pkg::REG_CENTER_MIN:    cfg_q.center_min  <= cfg_wdata_i;
        rip_pkg::REG_CENTER_MAX:    cfg_q.center_max  <= cfg_wdata_i;
        rip_pkg::REG_OFFSET_FIRST:  cfg_q.offset[0]   <= cfg_wdata_i;
        rip_pkg::REG_OFFSET_SECOND: cfg_q.offset[1]   <= cfg_wdata_i;
        rip_pkg::REG_OFFSET_THIRD:  cfg_q.offset[2]   <= cfg_wdata_i;
        rip_pkg::REG_PLAYERS:       cfg_q.players     <= cfg_wdata_i[rip_pkg::PlayerIdxW-1:0];
        default: ;
      endcase
    end
  end

  assign meas[0] = measured_x_0_i;
  assign meas[1] = measured_x_1_i;

  // front: registers the ball state, classifies rods, forms the products
  rip_front #(
    .RodCount (RodCount)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .full_o     (full),
    .ball_x_i   (ball_x_i),
    .ball_y_i   (ball_y_i),
    .ball_vx_i  (ball_vx_i),
    .ball_vy_i  (ball_vy_i),
    .meas_i     (meas),
    .mid_push_o (mid_push),
    .mid_o      (mid_wr),
    .mid_full_i (mid_full)
  );

  // short queue decoupling front and back
  rip_fifo #(
    .Width (MidW),
    .Depth (rip_pkg::MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wr),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rd),
    .empty_o (mid_empty)
  );

  // back: pipelined division, player choice, held targets
  rip_back #(
    .RodCount      (RodCount),
    .PlayersPerRod (PlayersPerRod)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_empty_i (mid_empty),
    .mid_i       (mid_rd),
    .mid_pop_o   (mid_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_wr)
  );

  // result queue, lets the pipeline keep going while a result waits
  rip_fifo #(
    .Width (ResW),
    .Depth (rip_pkg::ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_wr),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_rd),
    .empty_o (empty)
  );

  assign target_x_0_o = res_rd.target[0];
  assign target_x_1_o = res_rd.target[1];
  assign moved_0_o    = res_rd.moved[0];
  assign moved_1_o    = res_rd.moved[1];
  assign chosen_0_o   = res_rd.chosen[0];
  assign chosen_1_o   = res_rd.chosen[1];

endmodule

FILE: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rip_pkg::*;

  // one ball state as offered on the input side
  typedef struct packed {
    logic [DataW-1:0]       x;
    logic [DataW-1:0]       y;
    logic [DataW-1:0]       vx;
    logic [DataW-1:0]       vy;
    logic [1:0][DataW-1:0]  meas;
  } ball_t;

  // one planned outcome as seen on the result side
  typedef struct packed {
    logic [1:0][DataW-1:0]       target;
    logic [1:0]                  moved;
    logic [1:0][PlayerIdxW-1:0]  chosen;
  } plan_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_idx_i;
  logic [DataW-1:0]      cfg_wdata_i;
  logic                  push;
  logic                  full;
  logic                  empty;
  logic                  pop;
  logic [DataW-1:0]      ball_x, ball_y, ball_vx, ball_vy, meas_x0, meas_x1;
  logic [DataW-1:0]      target_x0, target_x1;
  logic                  moved0, moved1;
  logic [PlayerIdxW-1:0] chosen0, chosen1;

  // planner copy of the register file and of the held rod targets
  longint      line_m [2];
  longint      cmin_m;
  longint      cmax_m;
  longint      off_m [3];
  int unsigned players_m;
  longint      target_m [2];

  // outcomes planned at acceptance, oldest first
  plan_t plans_due [$];

  int fail_count;
  int items_taken;
  int results_seen;
  int moved_cnt [2];
  int pick_cnt [3];

  // idling controls for the sender and the receiver
  bit tx_gaps_on;
  bit rx_gaps_on;
  int hold_cycles;

  rod_intercept_planner dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .ball_x_i       (ball_x),
    .ball_y_i       (ball_y),
    .ball_vx_i      (ball_vx),
    .ball_vy_i      (ball_vy),
    .measured_x_0_i (meas_x0),
    .measured_x_1_i (meas_x1),
    .empty          (empty),
    .pop            (pop),
    .target_x_0_o   (target_x0),
    .target_x_1_o   (target_x1),
    .moved_0_o      (moved0),
    .moved_1_o      (moved1),
    .chosen_0_o     (chosen0),
    .chosen_1_o     (chosen1)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #(5_000_000);
    $display("tb: FAIL");
    $finish;
  end

  function automatic longint sx(input logic [DataW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // work out one transaction: crossing point per rod, nearest player in reach,
  // held target update; the held targets change as a side effect
  function automatic plan_t plan_intercepts(input ball_t b);
    plan_t  p;
    longint bx, by, vx, vy, line, prod, quot, est, lo, hi, d, best_d;
    int     np, best;
    bit     ahead, found;
    p  = '0;
    bx = sx(b.x);
    by = sx(b.y);
    vx = sx(b.vx);
    vy = sx(b.vy);
    np = (players_m > 3) ? 3 : int'(players_m);
    // a ball with no vertical motion leaves every rod alone
    if (vy != 0) begin
      for (int r = 0; r < 2; r++) begin
        line  = line_m[r];
        // a ball sitting on the line counts as not heading toward it
        ahead = (vy > 0) ? (line > by) : (line < by);
        if (ahead) begin
          prod   = (by - line) * vx;
          quot   = prod / vy;  // truncates toward zero
          est    = clamp16(bx - quot);
          found  = 1'b0;
          best   = 0;
          best_d = 0;
          for (int j = 0; j < np; j++) begin
            lo = cmin_m + off_m[j];
            hi = cmax_m + off_m[j];
            if (lo <= est && est <= hi) begin
              d = est - (sx(b.meas[r]) + off_m[j]);
              if (d < 0) d = -d;
              // strict compare keeps the lower index on a tie
              if (!found || d < best_d) begin
                found  = 1'b1;
                best_d = d;
                best   = j;
              end
            end
          end
          if (found) begin
            target_m[r]  = clamp16(est - off_m[best]);
            p.moved[r]   = 1'b1;
            p.chosen[r]  = PlayerIdxW'(best);
          end
        end
      end
    end
    p.target[0] = target_m[0][DataW-1:0];
    p.target[1] = target_m[1][DataW-1:0];
    return p;
  endfunction

  // every accepted transaction gets its outcome planned right at the edge
  always @(posedge clk_i) begin
    ball_t b;
    if (rst_ni && push && !full) begin
      b.x       = ball_x;
      b.y       = ball_y;
      b.vx      = ball_vx;
      b.vy      = ball_vy;
      b.meas[0] = meas_x0;
      b.meas[1] = meas_x1;
      plans_due.push_back(plan_intercepts(b));
      items_taken++;
    end
  end

  // compare each popped result with the oldest planned outcome
  always @(posedge clk_i) begin
    plan_t got, want;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      got.target[0] = target_x0;
      got.target[1] = target_x1;
      got.moved     = {moved1, moved0};
      got.chosen[0] = chosen0;
      got.chosen[1] = chosen1;
      if (plans_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("tb: result with nothing outstanding at %0t", $realtime);
      end else begin
        want = plans_due.pop_front();
        for (int r = 0; r < 2; r++) begin
          if (want.moved[r]) begin
            moved_cnt[r]++;
            pick_cnt[want.chosen[r]]++;
          end
        end
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("tb: mismatch at %0t: expected t0=%0d t1=%0d moved=%b c0=%0d c1=%0d",
                     $realtime, $signed(want.target[0]), $signed(want.target[1]),
                     want.moved, want.chosen[0], want.chosen[1]);
            $display("tb:   got t0=%0d t1=%0d moved=%b c0=%0d c1=%0d",
                     $signed(got.target[0]), $signed(got.target[1]), got.moved,
                     got.chosen[0], got.chosen[1]);
          end
        end
      end
    end
  end

  // result side: random pop gaps per transaction, plus an optional long hold
  initial begin : result_drain
    int gap;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      gap = rx_gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  // offer one ball state; push stays high on return so back-to-back
  // transactions never drop it within a step
  task automatic send_ball(input ball_t b);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    ball_x  <= b.x;
    ball_y  <= b.y;
    ball_vx <= b.vx;
    ball_vy <= b.vy;
    meas_x0 <= b.meas[0];
    meas_x1 <= b.meas[1];
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // stop offering, let every outstanding result come back, then allow for
  // the pipeline depth before anything touches the registers
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (plans_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [DataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_ROD_LINE_0:    line_m[0] = sx(data);
      REG_ROD_LINE_1:    line_m[1] = sx(data);
      REG_CENTER_MIN:    cmin_m    = sx(data);
      REG_CENTER_MAX:    cmax_m    = sx(data);
      REG_OFFSET_FIRST:  off_m[0]  = sx(data);
      REG_OFFSET_SECOND: off_m[1]  = sx(data);
      REG_OFFSET_THIRD:  off_m[2]  = sx(data);
      REG_PLAYERS:       players_m = data[1:0];
      default: ;
    endcase
  endtask

  task automatic load_defaults();
    cfg_write(REG_ROD_LINE_0, RstRodLine0);
    cfg_write(REG_ROD_LINE_1, RstRodLine1);
    cfg_write(REG_CENTER_MIN, RstCenterMin);
    cfg_write(REG_CENTER_MAX, RstCenterMax);
    cfg_write(REG_OFFSET_FIRST, RstOffset0);
    cfg_write(REG_OFFSET_SECOND, RstOffset1);
    cfg_write(REG_OFFSET_THIRD, RstOffset2);
    cfg_write(REG_PLAYERS, DataW'(RstPlayers));
  endtask

  function automatic logic [DataW-1:0] extreme_word();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'hFFFF;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  function automatic ball_t mk(input int x, input int y, input int vx, input int vy,
                               input int m0, input int m1);
    ball_t b;
    b.x       = DataW'(x);
    b.y       = DataW'(y);
    b.vx      = DataW'(vx);
    b.vy      = DataW'(vy);
    b.meas[0] = DataW'(m0);
    b.meas[1] = DataW'(m1);
    return b;
  endfunction

  // well-formed shot: pick a rod and a player span under the current
  // registers, choose the crossing point there and back out ball_x from it
  function automatic ball_t aimed_ball();
    ball_t  b;
    int     r, j;
    longint line, y, vx, vy, e, lo, hi, quot;
    b    = {$urandom, $urandom, $urandom};
    r    = $urandom_range(0, 1);
    line = line_m[r];
    case ($urandom_range(0, 3))
      0:       vy = $urandom_range(1, 16);
      1:       vy = $urandom_range(1, 2000);
      2:       vy = $urandom_range(1, 32767);
      default: vy = 256;
    endcase
    if ($urandom_range(0, 1)) vy = -vy;
    y  = (vy > 0) ? line - $urandom_range(1, 6000) : line + $urandom_range(1, 6000);
    y  = clamp16(y);
    vx = longint'($urandom_range(0, 6000)) - 3000;
    j  = $urandom_range(0, 2);
    lo = cmin_m + off_m[j];
    hi = cmax_m + off_m[j];
    if (lo > hi) begin
      e = sx(DataW'($urandom));
    end else begin
      e = lo - 64 + longint'($urandom_range(0, int'(hi - lo) + 128));
      // land exactly on a span boundary now and then
      if ($urandom_range(0, 7) == 0) e = $urandom_range(0, 1) ? lo : hi;
    end
    e         = clamp16(e);
    quot      = ((y - line) * vx) / vy;
    b.x       = DataW'(clamp16(e + quot));
    b.y       = DataW'(y);
    b.vx      = DataW'(vx);
    b.vy      = DataW'(vy);
    // rod center close to where some player would need it, for near ties
    b.meas[r] = DataW'(clamp16(e - off_m[$urandom_range(0, 2)]
                               + longint'($urandom_range(0, 1200)) - 600));
    return b;
  endfunction

  // mostly aimed shots, some without vertical motion, some noise and corners
  function automatic ball_t draw_ball();
    ball_t       b;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      b = aimed_ball();
    end else if (pick == 7) begin
      b    = aimed_ball();
      b.vy = '0;
    end else if (pick == 8) begin
      b = {$urandom, $urandom, $urandom};
    end else begin
      b = {extreme_word(), extreme_word(), extreme_word(),
           extreme_word(), extreme_word(), extreme_word()};
    end
    return b;
  endfunction

  function automatic logic [DataW-1:0] cfg_value(input longint base, input int unsigned span);
    if ($urandom_range(0, 4) == 0) return extreme_word();
    return DataW'(clamp16(base + longint'($urandom_range(0, span))));
  endfunction

  // center_min goes before center_max so the max can sit above the new min
  task automatic randomize_config();
    cfg_write(REG_ROD_LINE_0, cfg_value(-12000, 24000));
    cfg_write(REG_ROD_LINE_1, cfg_value(-12000, 24000));
    cfg_write(REG_CENTER_MIN, cfg_value(-6000, 8000));
    cfg_write(REG_CENTER_MAX, cfg_value(cmin_m, 9000));
    cfg_write(REG_OFFSET_FIRST, cfg_value(-4000, 3000));
    cfg_write(REG_OFFSET_SECOND, cfg_value(-1000, 2000));
    cfg_write(REG_OFFSET_THIRD, cfg_value(1000, 3000));
    cfg_write(REG_PLAYERS, DataW'($urandom));
  endtask

  // corner cases under the reset register values
  task automatic test_directed();
    send_ball(mk(3000, 0, 0, 0, 3000, 3000));          // no vertical motion
    send_ball(mk(4000, 0, 0, 256, 4000, 4000));        // both rods, middle player
    send_ball(mk(3000, 0, 0, 256, 4024, 4024));        // equal distance, lower index wins
    send_ball(mk(3000, 8000, 0, 256, 0, 0));           // moving away from both rods
    send_ball(mk(6000, 8000, 0, -256, 6000, 6000));    // moving down, outer player
    send_ball(mk(1000, 2560, 0, 256, 0, 0));           // on rod 0 line, only rod 1 ahead
    send_ball(mk(-5000, 0, 0, 1, 0, 0));               // outside every span, targets held
    send_ball(mk(3328, 0, 0, 256, 0, 0));              // top of the first player's span
    send_ball(mk(768, 0, 0, 256, 0, 0));               // bottom of the first player's span
    send_ball(mk(32767, -32768, 32767, 1, 0, 0));      // estimate clips high
    send_ball(mk(-32768, -32768, -32768, 1, 0, 0));    // estimate clips low
    send_ball(mk(2000, 0, 3, 7, 3000, 3000));          // negative quotient truncation
    send_ball(mk(2000, 0, -3, 7, 3000, 3000));         // positive quotient truncation
    send_ball(mk(1000, 0, 256, 256, 3500, 3500));      // slanted path
    send_ball(mk(3000, 20000, 100, -1, 0, 0));         // unit downward speed
    send_ball(mk(4000, 20000, 0, -32768, 4000, 4000)); // most negative speed
    send_ball(mk(32767, 32767, 32767, 32767, 32767, 32767));
    send_ball(mk(-32768, -32768, -32768, -32768, -32768, -32768));
    send_ball(mk(-1, -1, -1, -1, -1, -1));
    send_ball(mk(0, 0, 0, 0, 0, 0));
    wait_idle();
  endtask

  // every player count, zero meaning nobody may move
  task automatic test_player_count();
    for (int n = 0; n < 4; n++) begin
      cfg_write(REG_PLAYERS, DataW'(n));
      repeat (15) send_ball(draw_ball());
      wait_idle();
    end
    // upper data bits are not part of the count
    cfg_write(REG_PLAYERS, 16'hFFFD);
    repeat (10) send_ball(draw_ball());
    wait_idle();
  endtask

  // min above max: no player can reach anything
  task automatic test_reversed_span();
    cfg_write(REG_CENTER_MIN, RstCenterMax);
    cfg_write(REG_CENTER_MAX, RstCenterMin);
    repeat (15) send_ball(draw_ball());
    wait_idle();
  endtask

  // registers at their limits, including clipping of the stored target
  task automatic test_config_extremes();
    cfg_write(REG_ROD_LINE_0, 16'h7FFF);
    cfg_write(REG_ROD_LINE_1, 16'h8000);
    cfg_write(REG_CENTER_MIN, 16'h8000);
    cfg_write(REG_CENTER_MAX, 16'h7FFF);
    cfg_write(REG_OFFSET_FIRST, 16'h8000);
    cfg_write(REG_OFFSET_SECOND, 16'h0000);
    cfg_write(REG_OFFSET_THIRD, 16'h7FFF);
    cfg_write(REG_PLAYERS, 16'h0003);
    send_ball(mk(30000, 0, 0, 256, 30000, 30000));
    send_ball(mk(-30000, 0, 0, -256, -30000, -30000));
    repeat (25) send_ball(draw_ball());
    wait_idle();
    // single reachable point at zero, one player
    cfg_write(REG_ROD_LINE_0, 16'h0000);
    cfg_write(REG_ROD_LINE_1, 16'h0000);
    cfg_write(REG_CENTER_MIN, 16'h0000);
    cfg_write(REG_CENTER_MAX, 16'h0000);
    cfg_write(REG_OFFSET_FIRST, 16'h0000);
    cfg_write(REG_PLAYERS, 16'h0001);
    send_ball(mk(0, -100, 0, 256, 0, 0));
    send_ball(mk(1, -100, 0, 256, 0, 0));
    repeat (15) send_ball(draw_ball());
    wait_idle();
    load_defaults();
  endtask

  // receiver stops for a long stretch while the sender keeps pushing,
  // so both internal queues fill and full must hold off the input
  task automatic test_receiver_hold();
    tx_gaps_on  = 1'b0;
    hold_cycles = 300;
    repeat (100) send_ball(aimed_ball());
    wait_idle();
    tx_gaps_on = 1'b1;
  endtask

  // random register sets, cycling through four idling mixes
  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      randomize_config();
      tx_gaps_on = (ph % 4 == 0) || (ph % 4 == 2);
      rx_gaps_on = (ph % 4 == 0) || (ph % 4 == 3);
      repeat (110) send_ball(draw_ball());
      wait_idle();
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_ROD_LINE_0;
    cfg_wdata_i <= '0;
    push        <= 1'b0;
    ball_x      <= '0;
    ball_y      <= '0;
    ball_vx     <= '0;
    ball_vy     <= '0;
    meas_x0     <= '0;
    meas_x1     <= '0;
    tx_gaps_on  = 1'b1;
    rx_gaps_on  = 1'b1;
    // planner state after reset
    line_m[0]   = sx(RstRodLine0);
    line_m[1]   = sx(RstRodLine1);
    cmin_m      = sx(RstCenterMin);
    cmax_m      = sx(RstCenterMax);
    off_m[0]    = sx(RstOffset0);
    off_m[1]    = sx(RstOffset1);
    off_m[2]    = sx(RstOffset2);
    players_m   = RstPlayers;
    target_m[0] = 0;
    target_m[1] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_player_count();
    test_reversed_span();
    test_config_extremes();
    test_receiver_hold();
    test_random_phases();
    wait_idle();

    $display("tb: %0d ball states planned, %0d results checked, %0d failures",
             items_taken, results_seen, fail_count);
    $display("tb: rod moves %0d/%0d, player picks %0d/%0d/%0d, input stalled by a long hold",
             moved_cnt[0], moved_cnt[1], pick_cnt[0], pick_cnt[1], pick_cnt[2]);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: rod_intercept_planner.f
rtl/rip_pkg.sv
rtl/rip_fifo.sv
rtl/rip_front.sv
rtl/rip_div.sv
rtl/rip_back.sv
rtl/rod_intercept_planner.sv
sim/tb.sv
